/* rtl/core/dst_pkg.sv */
// Shared types and constants of the detection stability tracker.
package dst_pkg;

   localparam int TIME_BITS    = 40;
   localparam int RUN_BITS     = 16;
   localparam int THR_BITS     = 12;
   localparam int AREA_Q_BITS  = 10;
   localparam int WIN_BITS     = 16;
   localparam int WIN_US_BITS  = 26;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [9:0] USEC_PER_MS = 10'd1000;
   localparam logic [RUN_BITS-1:0] RUN_MAX = 16'hFFFF;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MOVE_THRESH    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AREA_THRESH    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_ENABLE    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_MOVE      = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_AREA      = 3'd5;

   typedef struct packed {
      logic [THR_BITS-1:0]    move_thresh;
      logic [AREA_Q_BITS-1:0] area_thresh_q8;
      logic                   span_enable;
      logic [WIN_BITS-1:0]    span_window_ms;
      logic [THR_BITS-1:0]    span_move_thresh;
      logic [AREA_Q_BITS-1:0] span_area_thresh_q8;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPAN_RD,
      ST_SPAN_EV,
      ST_EMIT
   } back_state_type;

endpackage

/* rtl/core/dst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/dst_fifo.sv */
// Small register queue of finished frame records between front and back.
module dst_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];
endmodule

/* rtl/core/dst_front.sv */
// Front part: takes region items, keeps the largest, and queues a record per frame.
module dst_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      has_region,
   input  logic [4*COORD_BITS-1:0]   rect,
   input  logic [dst_pkg::TIME_BITS-1:0] frame_time,
   input  logic                      frame_end,
   output logic                      push,
   output logic [6*COORD_BITS+dst_pkg::TIME_BITS:0] push_data
);
   localparam int CB = COORD_BITS;

   logic [4*CB-1:0] best_rect_ff, best_rect_in;
   logic [2*CB-1:0] best_area_ff, best_area_in;
   logic            best_valid_ff, best_valid_in;
   logic [2*CB-1:0] area;
   logic            take;

   always_comb begin
      area = (2*CB)'(rect[3*CB +: CB]) * (2*CB)'(rect[2*CB +: CB]);
      take = has_region && (!best_valid_ff || area > best_area_ff);
      best_rect_in  = take ? rect : best_rect_ff;
      best_area_in  = take ? area : best_area_ff;
      best_valid_in = best_valid_ff | take;
      push      = accept && frame_end;
      push_data = {frame_time, best_area_in, best_rect_in, best_valid_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_rect_ff  <= '0;
         best_area_ff  <= '0;
         best_valid_ff <= 1'b0;
      end else if (accept) begin
         // A frame end hands the best region on and starts the next frame clean.
         if (frame_end) begin
            best_rect_ff  <= '0;
            best_area_ff  <= '0;
            best_valid_ff <= 1'b0;
         end else begin
            best_rect_ff  <= best_rect_in;
            best_area_ff  <= best_area_in;
            best_valid_ff <= best_valid_in;
         end
      end
   end
endmodule

/* rtl/core/dst_back.sv */
// Back part: run counts, reference re-basing, history ring and span check per frame.
module dst_back #(
   parameter int COORD_BITS    = 12,
   parameter int HISTORY_DEPTH = 32,
   parameter int OUT_TW        = 72
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dst_pkg::cfg_type      cfg,
   input  logic                  rec_valid,
   input  logic [6*COORD_BITS+dst_pkg::TIME_BITS:0] rec_data,
   output logic                  rec_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_TW-1:0]     rsp_tdata
);
   localparam int CB = COORD_BITS;
   localparam int TB = dst_pkg::TIME_BITS;
   localparam int RW = 4*CB;
   localparam int AR = 2*CB;
   localparam int HW = 6*CB + TB;
   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int DW = 17;
   localparam int PW = AR + 10;

   dst_pkg::back_state_type state_ff, state_in;
   logic [RW-1:0] cur_rect_ff, cur_rect_in, ref_rect_ff, ref_rect_in;
   logic [AR-1:0] cur_area_ff, cur_area_in, ref_area_ff, ref_area_in;
   logic [TB-1:0] cur_time_ff, cur_time_in;
   logic          cur_det_ff, cur_det_in, big_ff, big_in, uns_ff, uns_in;
   logic [dst_pkg::RUN_BITS-1:0] run_ff, run_in, miss_ff, miss_in;
   logic [AW-1:0] head_ff, head_in, idx_ff, idx_in, idx_dec;
   logic [CW-1:0] count_ff, count_in, k_ff, k_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [OUT_TW-1:0] rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [HW-1:0] ram_rdata;
   logic [RW-1:0] hist_rect, cmp_rect;
   logic [AR-1:0] hist_area, cmp_area;
   logic [TB-1:0] hist_time;
   logic [dst_pkg::THR_BITS-1:0]    cmp_mthr;
   logic [dst_pkg::AREA_Q_BITS-1:0] cmp_athr;
   logic          moved;
   logic [dst_pkg::WIN_US_BITS-1:0] window;
   logic          older;

   // Centre shift or relative area change of a against b, b being the newest region.
   function automatic logic rect_moved(input logic [RW-1:0] a, input logic [AR-1:0] aa,
                                       input logic [RW-1:0] b, input logic [AR-1:0] ab,
                                       input logic [dst_pkg::THR_BITS-1:0] mthr,
                                       input logic [dst_pkg::AREA_Q_BITS-1:0] athr);
      logic [DW-1:0] ax, ay, bx, by, dx, dy;
      logic [AR-1:0] d;
      logic [PW-1:0] lhs, rhs;
      logic          f;
      ax = DW'(a[0 +: CB]) + DW'(a[2*CB +: CB] >> 1);
      ay = DW'(a[CB +: CB]) + DW'(a[3*CB +: CB] >> 1);
      bx = DW'(b[0 +: CB]) + DW'(b[2*CB +: CB] >> 1);
      by = DW'(b[CB +: CB]) + DW'(b[3*CB +: CB] >> 1);
      dx = (ax > bx) ? ax - bx : bx - ax;
      dy = (ay > by) ? ay - by : by - ay;
      f  = (dx > DW'(mthr)) || (dy > DW'(mthr));
      d   = (aa > ab) ? aa - ab : ab - aa;
      lhs = PW'({d, 8'b0});
      rhs = PW'(athr) * PW'(ab);
      if (ab != '0 && lhs > rhs) begin
         f = 1'b1;
      end
      return f;
   endfunction

   assign hist_rect = ram_rdata[0 +: RW];
   assign hist_area = ram_rdata[RW +: AR];
   assign hist_time = ram_rdata[RW+AR +: TB];
   assign idx_dec   = (idx_ff == '0) ? AW'(HISTORY_DEPTH - 1) : idx_ff - 1'b1;
   assign window    = dst_pkg::WIN_US_BITS'(cfg.span_window_ms) *
                      dst_pkg::WIN_US_BITS'(dst_pkg::USEC_PER_MS);
   assign older     = (hist_time <= cur_time_ff) &&
                      ((cur_time_ff - hist_time) > TB'(window));

   always_comb begin
      if (state_ff == dst_pkg::ST_SPAN_EV) begin
         cmp_rect = hist_rect;
         cmp_area = hist_area;
         cmp_mthr = cfg.span_move_thresh;
         cmp_athr = cfg.span_area_thresh_q8;
      end else begin
         cmp_rect = ref_rect_ff;
         cmp_area = ref_area_ff;
         cmp_mthr = cfg.move_thresh;
         cmp_athr = cfg.area_thresh_q8;
      end
      moved = rect_moved(cmp_rect, cmp_area, cur_rect_ff, cur_area_ff, cmp_mthr, cmp_athr);
   end

   always_comb begin
      state_in    = state_ff;
      cur_rect_in = cur_rect_ff;
      cur_area_in = cur_area_ff;
      cur_time_in = cur_time_ff;
      cur_det_in  = cur_det_ff;
      ref_rect_in = ref_rect_ff;
      ref_area_in = ref_area_ff;
      big_in      = big_ff;
      uns_in      = uns_ff;
      run_in      = run_ff;
      miss_in     = miss_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      rec_pop     = 1'b0;
      ram_we      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         dst_pkg::ST_IDLE: begin
            if (rec_valid) begin
               rec_pop     = 1'b1;
               cur_det_in  = rec_data[0];
               cur_rect_in = rec_data[1 +: RW];
               cur_area_in = rec_data[1+RW +: AR];
               cur_time_in = rec_data[1+RW+AR +: TB];
               big_in      = 1'b0;
               uns_in      = 1'b0;
               state_in    = dst_pkg::ST_EMIT;
               if (!rec_data[0]) begin
                  run_in      = '0;
                  miss_in     = (miss_ff != dst_pkg::RUN_MAX) ? miss_ff + 1'b1 : miss_ff;
                  ref_rect_in = '0;
                  ref_area_in = '0;
                  head_in     = '0;
                  count_in    = '0;
               end else begin
                  ram_we   = 1'b1;
                  head_in  = (head_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = (count_ff == CW'(HISTORY_DEPTH)) ? count_ff : count_ff + 1'b1;
                  run_in   = (run_ff != dst_pkg::RUN_MAX) ? run_ff + 1'b1 : run_ff;
                  miss_in  = '0;
                  if (run_ff == '0) begin
                     ref_rect_in = rec_data[1 +: RW];
                     ref_area_in = rec_data[1+RW +: AR];
                  end else begin
                     state_in = dst_pkg::ST_CHECK;
                  end
               end
            end
         end
         dst_pkg::ST_CHECK: begin
            big_in = moved;
            if (moved) begin
               ref_rect_in = cur_rect_ff;
               ref_area_in = cur_area_ff;
            end
            idx_in   = head_ff;
            k_in     = '0;
            state_in = cfg.span_enable ? dst_pkg::ST_SPAN_RD : dst_pkg::ST_EMIT;
         end
         dst_pkg::ST_SPAN_RD: begin
            if (k_ff == count_ff) begin
               state_in = dst_pkg::ST_EMIT;
            end else begin
               idx_in   = idx_dec;
               k_in     = k_ff + 1'b1;
               state_in = dst_pkg::ST_SPAN_EV;
            end
         end
         dst_pkg::ST_SPAN_EV: begin
            if (older) begin
               uns_in   = moved;
               state_in = dst_pkg::ST_EMIT;
            end else begin
               state_in = dst_pkg::ST_SPAN_RD;
            end
         end
         dst_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_TW'({run_ff, uns_ff, big_ff, cur_det_ff, cur_rect_ff});
               state_in     = dst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dst_pkg::ST_IDLE;
         ref_rect_ff  <= '0;
         ref_area_ff  <= '0;
         run_ff       <= '0;
         miss_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_rect_ff  <= ref_rect_in;
         ref_area_ff  <= ref_area_in;
         run_ff       <= run_in;
         miss_ff      <= miss_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_rect_ff <= cur_rect_in;
      cur_area_ff <= cur_area_in;
      cur_time_ff <= cur_time_in;
      cur_det_ff  <= cur_det_in;
      big_ff      <= big_in;
      uns_ff      <= uns_in;
      idx_ff      <= idx_in;
      k_ff        <= k_in;
      rsp_data_ff <= rsp_data_in;
   end

   dst_ram #(.WIDTH(HW), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock (clock),
      .we    (ram_we),
      .waddr (head_ff),
      .wdata ({rec_data[1+RW+AR +: TB], rec_data[1+RW +: AR], rec_data[1 +: RW]}),
      .raddr (idx_dec),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

/* rtl/core/detection_stability_tracker.sv */
// Top level of the detection stability tracker.
//
// Input channel req_*: one detected rectangle per transfer, req_tuser = 1 when the
// transfer carries a rectangle, req_tlast = 1 on the last transfer of a frame. A
// frame without detections is a single transfer with req_tuser = 0, req_tlast = 1.
// Output channel rsp_*: one result per frame, issued after the frame's last transfer.
// Configuration: csr_we writes csr_wdata into register csr_index.
// Region transfers are taken one per cycle while the queue is not full; the front
// keeps the largest area. Each frame is queued (two entries) to the back, which takes
// the record in its idle step, compares it with the reference in a check step (skipped
// for a miss or a first detection) and, with the span check on, walks the history
// through the RAM read port, reading and then evaluating one entry at a time from the
// newest until one is older than the window or all filled entries are walked. The
// result is then registered in the emit step. A stalled rsp_tready holds the result
// register; the back then waits in its emit step and the front stops once the queue
// is full. Reset clears counts, reference region, history pointers and the queue;
// the history RAM itself is not cleared, only entries counted as filled are read.
module detection_stability_tracker #(
   parameter int HISTORY_DEPTH = 32,
   parameter int COORD_BITS    = 12
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // From bit 0: rect_x, rect_y, rect_w, rect_h, frame_time_us, zero fill.
   input  logic [((4*COORD_BITS+dst_pkg::TIME_BITS+7)/8)*8-1:0] req_tdata,
   // has_region.
   input  logic req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // From bit 0: out_x, out_y, out_w, out_h, detected, big_displacement,
   // position_unsteady, run_length, zero fill.
   output logic [((4*COORD_BITS+19+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_we,
   input  logic [dst_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [dst_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int CB     = COORD_BITS;
   localparam int REC_W  = 6*CB + dst_pkg::TIME_BITS + 1;
   localparam int OUT_TW = ((4*CB + 19 + 7) / 8) * 8;

   dst_pkg::cfg_type cfg_ff, cfg_in;
   logic             accept, push, full, pop, not_empty;
   logic [REC_W-1:0] push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dst_pkg::CSR_MOVE_THRESH: cfg_in.move_thresh = csr_wdata[11:0];
            dst_pkg::CSR_AREA_THRESH: cfg_in.area_thresh_q8 = csr_wdata[9:0];
            dst_pkg::CSR_SPAN_ENABLE: cfg_in.span_enable = csr_wdata[0];
            dst_pkg::CSR_SPAN_WINDOW: cfg_in.span_window_ms = csr_wdata;
            dst_pkg::CSR_SPAN_MOVE:   cfg_in.span_move_thresh = csr_wdata[11:0];
            dst_pkg::CSR_SPAN_AREA:   cfg_in.span_area_thresh_q8 = csr_wdata[9:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_thresh         <= 12'd7;
         cfg_ff.area_thresh_q8      <= 10'd51;
         cfg_ff.span_enable         <= 1'b0;
         cfg_ff.span_window_ms      <= '0;
         cfg_ff.span_move_thresh    <= '0;
         cfg_ff.span_area_thresh_q8 <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   dst_front #(.COORD_BITS(CB)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .has_region (req_tuser),
      .rect       (req_tdata[4*CB-1:0]),
      .frame_time (req_tdata[4*CB +: dst_pkg::TIME_BITS]),
      .frame_end  (req_tlast),
      .push       (push),
      .push_data  (push_data)
   );

   dst_fifo #(.WIDTH(REC_W), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   dst_back #(.COORD_BITS(CB), .HISTORY_DEPTH(HISTORY_DEPTH), .OUT_TW(OUT_TW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .rec_valid  (not_empty),
      .rec_data   (pop_data),
      .rec_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // A frame without detections reports no flags and a cleared run count.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4*CB] |->
      rsp_tdata[4*CB+1] == 1'b0 && rsp_tdata[4*CB+2] == 1'b0 &&
      rsp_tdata[4*CB+3 +: 16] == '0)
      else $error("miss result carries flags or a run count");
   // A detecting frame always has a nonzero run count.
   a_hit_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4*CB] |-> rsp_tdata[4*CB+3 +: 16] != '0)
      else $error("detecting result with zero run count");
   // The queue never takes a record while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("frame record pushed into a full queue");
`endif
endmodule

/* bench/detection_stability_tracker_tb.sv */
// Self-checking testbench for the detection stability tracker.
`timescale 1ns / 1ps

module detection_stability_tracker_tb;

   localparam int DEPTH = 32;
   localparam int CB = 12;
   localparam int REQ_W = ((4*CB+dst_pkg::TIME_BITS+7)/8)*8;
   localparam int RSP_W = ((4*CB+19+7)/8)*8;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [CB-1:0] x, y, w, h;
   } box_type;

   typedef struct packed {
      box_type       box;
      logic          detected;
      logic          big;
      logic          unsteady;
      logic [15:0]   run;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [dst_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [dst_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   detection_stability_tracker u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   dst_pkg::cfg_type cfg;
   box_type best_box, ref_box, last_box;
   logic [23:0] best_area;
   logic best_valid;
   logic [15:0] detect_run;
   box_type hist_box[DEPTH];
   logic [dst_pkg::TIME_BITS-1:0] hist_time[DEPTH];
   int hist_count, hist_head;

   frame_result_type results_due[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int rsp_wait = 0;

   function automatic bit box_moved(box_type a, box_type b,
                                    logic [dst_pkg::THR_BITS-1:0] mthr,
                                    logic [dst_pkg::AREA_Q_BITS-1:0] athr);
      longint ax, ay, bx, by, aa, ab, d;
      bit flag;
      ax = a.x + a.w / 2; ay = a.y + a.h / 2;
      bx = b.x + b.w / 2; by = b.y + b.h / 2;
      aa = longint'(a.w) * a.h; ab = longint'(b.w) * b.h;
      flag = 0;
      if ((ax > bx ? ax - bx : bx - ax) > mthr || (ay > by ? ay - by : by - ay) > mthr)
         flag = 1;
      if (ab != 0) begin
         d = aa > ab ? aa - ab : ab - aa;
         if (d * 256 > longint'(athr) * ab) flag = 1;
      end
      return flag;
   endfunction

   task automatic track_item(bit has, box_type b, logic [dst_pkg::TIME_BITS-1:0] now,
                             bit last);
      logic [23:0] area;
      frame_result_type r;
      longint win;
      int idx;
      if (has) begin
         area = b.w * b.h;
         if (!best_valid || area > best_area) begin
            best_box = b; best_area = area; best_valid = 1;
         end
      end
      if (!last) return;
      r = '{box: '{0, 0, 0, 0}, detected: best_valid, big: 0, unsteady: 0, run: 0};
      if (!best_valid) begin
         detect_run = 0;
         ref_box = '{0, 0, 0, 0}; last_box = '{0, 0, 0, 0};
         hist_count = 0; hist_head = 0;
      end else begin
         last_box = best_box;
         hist_box[hist_head] = last_box;
         hist_time[hist_head] = now;
         hist_head = (hist_head + 1) % DEPTH;
         if (hist_count < DEPTH) hist_count++;
         if (detect_run != dst_pkg::RUN_MAX) detect_run++;
         if (detect_run == 1) begin
            ref_box = last_box;
         end else begin
            r.big = box_moved(ref_box, last_box, cfg.move_thresh, cfg.area_thresh_q8);
            if (r.big) ref_box = last_box;
            if (cfg.span_enable) begin
               win = longint'(cfg.span_window_ms) * 1000;
               idx = hist_head;
               for (int k = 0; k < hist_count; k++) begin
                  idx = (idx == 0) ? DEPTH - 1 : idx - 1;
                  if (hist_time[idx] <= now && longint'(now - hist_time[idx]) > win) begin
                     r.unsteady = box_moved(hist_box[idx], last_box,
                                            cfg.span_move_thresh, cfg.span_area_thresh_q8);
                     break;
                  end
               end
            end
         end
         r.box = last_box;
      end
      r.run = detect_run;
      best_valid = 0; best_area = 0; best_box = '{0, 0, 0, 0};
      results_due = {results_due, r};
   endtask

   // Valid stays high after a transfer when the next item follows without a gap.
   task automatic send_item(bit has, box_type b, logic [dst_pkg::TIME_BITS-1:0] now,
                            bit last);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 13));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= has;
      req_tlast <= last;
      req_tdata <= {now, b.h, b.w, b.y, b.x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_item(has, b, now, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (results_due.size() != 0 && !timed_out) @(posedge clock);
      repeat (DEPTH * 2 + 10) @(posedge clock);
   endtask

   task automatic write_reg(logic [dst_pkg::CSR_IDX_BITS-1:0] idx, logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         dst_pkg::CSR_MOVE_THRESH: cfg.move_thresh = val[11:0];
         dst_pkg::CSR_AREA_THRESH: cfg.area_thresh_q8 = val[9:0];
         dst_pkg::CSR_SPAN_ENABLE: cfg.span_enable = val[0];
         dst_pkg::CSR_SPAN_WINDOW: cfg.span_window_ms = val;
         dst_pkg::CSR_SPAN_MOVE:   cfg.span_move_thresh = val[11:0];
         dst_pkg::CSR_SPAN_AREA:   cfg.span_area_thresh_q8 = val[9:0];
         default: ;
      endcase
   endtask

   function automatic box_type rand_box(int maxv);
      box_type b;
      b.x = CB'($urandom_range(0, maxv)); b.y = CB'($urandom_range(0, maxv));
      b.w = CB'($urandom_range(0, maxv)); b.h = CB'($urandom_range(0, maxv));
      return b;
   endfunction

   logic [dst_pkg::TIME_BITS-1:0] clock_us = 0;

   // A frame of n regions; n = 0 sends one empty item.
   task automatic send_frame(int n, box_type base, int jitter, int step_us);
      box_type b;
      clock_us = clock_us + dst_pkg::TIME_BITS'(step_us);
      if (n == 0) begin
         send_item(0, rand_box(4095), clock_us, 1);
         return;
      end
      for (int i = 0; i < n; i++) begin
         b = base;
         b.x = base.x + CB'($urandom_range(0, jitter));
         b.y = base.y + CB'($urandom_range(0, jitter));
         b.w = base.w + CB'($urandom_range(0, jitter));
         b.h = base.h + CB'($urandom_range(0, jitter));
         // Rarely sprinkle ignored items between regions.
         if ($urandom_range(0, 9) == 0) send_item(0, rand_box(4095), clock_us, 0);
         send_item(1, b, clock_us, i == n - 1);
      end
   endtask

   task automatic test_directed();
      box_type z, m;
      z = '{0, 0, 0, 0}; m = '{4095, 4095, 4095, 4095};
      send_frame(0, z, 0, 1000);
      send_item(1, m, clock_us, 1);
      send_item(1, z, clock_us + 5, 1);
      send_item(1, '{10, 10, 20, 20}, clock_us + 9, 0);
      send_item(1, '{30, 30, 20, 20}, clock_us + 9, 0);
      send_item(1, '{50, 50, 5, 5}, clock_us + 9, 1);
      send_item(1, '{100, 100, 20, 20}, clock_us + 20, 1);
      send_item(1, '{101, 100, 20, 21}, clock_us + 30, 1);
      send_item(0, m, 40'hFF_FFFF_FFFF, 0);
      send_item(1, '{101, 100, 20, 21}, 40'hFF_FFFF_FFFF, 1);
      send_item(1, '{101, 100, 20, 21}, 40'h0, 1);
      send_frame(0, z, 0, 10);
      send_frame(0, z, 0, 10);
      drain();
   endtask

   task automatic test_span_extremes();
      write_reg(dst_pkg::CSR_SPAN_ENABLE, 16'd1);
      write_reg(dst_pkg::CSR_SPAN_WINDOW, 16'd0);
      write_reg(dst_pkg::CSR_SPAN_MOVE, 16'd0);
      write_reg(dst_pkg::CSR_SPAN_AREA, 16'd0);
      write_reg(dst_pkg::CSR_MOVE_THRESH, 16'd0);
      write_reg(dst_pkg::CSR_AREA_THRESH, 16'd0);
      for (int i = 0; i < 40; i++) send_frame($urandom_range(1, 3), '{200, 200, 30, 30}, 3, 1);
      drain();
      write_reg(dst_pkg::CSR_SPAN_WINDOW, 16'hFFFF);
      write_reg(dst_pkg::CSR_SPAN_MOVE, 16'hFFF);
      write_reg(dst_pkg::CSR_SPAN_AREA, 16'h3FF);
      write_reg(dst_pkg::CSR_MOVE_THRESH, 16'hFFF);
      write_reg(dst_pkg::CSR_AREA_THRESH, 16'h3FF);
      for (int i = 0; i < 20; i++) send_frame(1, rand_box(4095), 0, 40_000_000);
      drain();
   endtask

   task automatic test_random_phase(int items);
      int sent;
      int n;
      box_type base;
      sent = 0;
      base = rand_box(3000);
      while (sent < items) begin
         n = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 4);
         if ($urandom_range(0, 15) == 0) base = rand_box(3000);
         if ($urandom_range(0, 19) == 0)
            clock_us = dst_pkg::TIME_BITS'({$urandom, $urandom});
         send_frame(n, base, $urandom_range(0, 1) ? 2 : 60,
                    $urandom_range(0, 3) == 0 ? $urandom_range(0, 3000000) :
                    $urandom_range(0, 40000));
         sent += n == 0 ? 1 : n;
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 12; i++) send_frame(2, '{500, 500, 40, 40}, 8, 2000);
      drain();
   endtask

   task automatic test_settings();
      test_random_phase(300);
      write_reg(dst_pkg::CSR_MOVE_THRESH, 16'($urandom_range(0, 20)));
      write_reg(dst_pkg::CSR_AREA_THRESH, 16'($urandom_range(0, 120)));
      write_reg(dst_pkg::CSR_SPAN_ENABLE, 16'd1);
      write_reg(dst_pkg::CSR_SPAN_WINDOW, 16'($urandom_range(5, 60)));
      write_reg(dst_pkg::CSR_SPAN_MOVE, 16'($urandom_range(0, 30)));
      write_reg(dst_pkg::CSR_SPAN_AREA, 16'($urandom_range(0, 200)));
      test_random_phase(450);
      write_reg(dst_pkg::CSR_SPAN_ENABLE, 16'd0);
      write_reg(dst_pkg::CSR_MOVE_THRESH, 16'd4095);
      test_random_phase(350);
   endtask

   // Receiver side: a drawn wait before each result plus one long hold-off.
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
         hold_left <= 0;
      end else if (hold_requests != hold_seen) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         draw = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 13));
         rsp_wait <= draw;
         rsp_tready <= (draw == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker and stall watchdog.
   always @(posedge clock) begin
      frame_result_type e;
      frame_result_type a;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) timed_out <= 1;
         if (rsp_tvalid && rsp_tready) begin
            a.box = '{rsp_tdata[11:0], rsp_tdata[23:12], rsp_tdata[35:24], rsp_tdata[47:36]};
            a.detected = rsp_tdata[48];
            a.big = rsp_tdata[49];
            a.unsteady = rsp_tdata[50];
            a.run = rsp_tdata[66:51];
            if (results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               e = results_due.pop_front();
               if (a != e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %p got %p", e, a);
               end
            end
         end
      end
   end

   initial begin
      cfg = '{move_thresh: 7, area_thresh_q8: 51, span_enable: 0, span_window_ms: 0,
              span_move_thresh: 0, span_area_thresh_q8: 0};
      best_box = '{0, 0, 0, 0}; ref_box = best_box; last_box = best_box;
      best_area = 0; best_valid = 0; detect_run = 0; hist_count = 0; hist_head = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         begin
            test_directed();
            test_span_extremes();
            test_backpressure();
            test_settings();
         end
         wait (timed_out);
      join_any
      if (timed_out) begin
         $display("[FAIL] regression broken");
      end else if (mismatches == 0 && results_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
